// File: rtl/ida_pkg.sv
// Shared types, codes and defaults for the ID allocator with owner table.
package ida_pkg;

   localparam int ID_BITS           = 8;
   localparam int OWNER_PORT_BITS   = 16;
   localparam int CMD_BITS          = 2;
   localparam int STATUS_BITS       = 2;
   localparam int DEFAULT_MAX_IDS   = 255;
   localparam int DEFAULT_OWNER_BITS = 16;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ALLOC    = 2'd0,
      CMD_RELEASE  = 2'd1,
      CMD_LOOKUP   = 2'd2,
      CMD_TRANSFER = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      RSP_OK      = 2'd0,
      RSP_INVALID = 2'd1,
      RSP_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EVAL
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic accept;
      logic fire;
   } ida_ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } ida_stat_type;

endpackage

// File: rtl/ida_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ida_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 256,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ida_ctrl.sv
// Controller state machine: clearing pass, request accept and evaluation.
module ida_ctrl
   import ida_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ida_stat_type stat,
   output ida_ctrl_type ctrl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_EVAL;
         end
         S_EVAL: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      ctrl.clear  = 1'b0;
      ctrl.accept = 1'b0;
      ctrl.fire   = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            ctrl.clear = 1'b1;
         end
         S_IDLE: begin
            req_ready   = 1'b1;
            ctrl.accept = req_valid;
         end
         S_EVAL: begin
            // The word is finished only when the output register can take it.
            ctrl.fire = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/ida_dp.sv
// Datapath: owner table, live bits, free stack, counters and result register.
module ida_dp
   import ida_pkg::*;
#(
   parameter int MAX_IDS    = DEFAULT_MAX_IDS,
   parameter int OWNER_BITS = DEFAULT_OWNER_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ida_ctrl_type               ctrl,
   output ida_stat_type               stat,
   input  logic [CMD_BITS-1:0]        req_command,
   input  logic [ID_BITS-1:0]         req_id,
   input  logic [OWNER_PORT_BITS-1:0] req_owner,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_BITS-1:0]     rsp_status,
   output logic [ID_BITS-1:0]         rsp_result_id,
   output logic [OWNER_PORT_BITS-1:0] rsp_result_owner
);

   localparam int AW = $clog2(MAX_IDS);
   localparam int IW = $clog2(MAX_IDS + 1);
   localparam int CW = (IW > ID_BITS) ? IW : ID_BITS;

   // Latched request.
   cmd_type               cmd_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic [AW-1:0]         id_addr_ff;
   logic [OWNER_BITS-1:0] own_ff;
   logic                  id_ok_ff;
   logic                  pop_ff;

   logic [IW-1:0] free_count_ff, free_count_in;
   logic [IW-1:0] last_fresh_ff, last_fresh_in;
   logic [AW-1:0] clr_addr_ff;

   logic                       rsp_valid_ff;
   logic [STATUS_BITS-1:0]     rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]         rsp_id_ff, rsp_id_in;
   logic [OWNER_PORT_BITS-1:0] rsp_owner_ff, rsp_owner_in;

   // Request decode.
   cmd_type       req_cmd;
   logic [CW-1:0] req_id_ext;
   logic          req_id_ok;
   logic [AW-1:0] req_addr;

   // RAM ports.
   logic                  own_we, live_we, stk_we;
   logic [AW-1:0]         own_waddr, live_waddr, stk_waddr;
   logic [OWNER_BITS-1:0] own_wdata, own_rdata;
   logic                  live_wdata, live_rdata;
   logic [IW-1:0]         stk_wdata, stk_rdata;
   logic                  own_re, stk_re;
   logic [AW-1:0]         stk_raddr;

   // Evaluation.
   logic          live_ok, owner_match, alloc_ok;
   logic [IW-1:0] got;
   logic [AW-1:0] got_addr;

   assign req_cmd    = cmd_type'(req_command);
   assign req_id_ext = CW'(req_id);
   assign req_id_ok  = (req_id_ext != '0) && (req_id_ext <= CW'(MAX_IDS));
   assign req_addr   = AW'(req_id_ext - CW'(1));

   assign own_re    = ctrl.accept && (req_cmd != CMD_ALLOC) && req_id_ok;
   assign stk_re    = ctrl.accept && (req_cmd == CMD_ALLOC) && (free_count_ff != '0);
   assign stk_raddr = AW'(free_count_ff - IW'(1));

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         cmd_ff     <= req_cmd;
         id_ff      <= req_id;
         id_addr_ff <= req_addr;
         own_ff     <= OWNER_BITS'(req_owner);
         id_ok_ff   <= req_id_ok;
         pop_ff     <= (free_count_ff != '0);
      end
   end

   always_comb begin
      live_ok     = id_ok_ff && live_rdata;
      owner_match = (own_rdata == own_ff);
      alloc_ok    = 1'b1;
      got         = stk_rdata;
      if (!pop_ff) begin
         got      = last_fresh_ff + IW'(1);
         alloc_ok = (last_fresh_ff != IW'(MAX_IDS));
      end
      got_addr = AW'(got - IW'(1));
   end

   always_comb begin
      own_we        = 1'b0;
      own_waddr     = id_addr_ff;
      own_wdata     = own_ff;
      live_we       = 1'b0;
      live_waddr    = id_addr_ff;
      live_wdata    = 1'b0;
      stk_we        = 1'b0;
      stk_waddr     = AW'(free_count_ff);
      stk_wdata     = IW'(id_ff);
      free_count_in = free_count_ff;
      last_fresh_in = last_fresh_ff;
      rsp_status_in = RSP_INVALID;
      rsp_id_in     = id_ff;
      rsp_owner_in  = '0;

      if (ctrl.clear) begin
         live_we    = 1'b1;
         live_waddr = clr_addr_ff;
      end

      if (ctrl.fire) begin
         case (cmd_ff)
            CMD_ALLOC: begin
               if (alloc_ok) begin
                  rsp_status_in = RSP_OK;
                  rsp_id_in     = ID_BITS'(got);
                  own_we        = 1'b1;
                  own_waddr     = got_addr;
                  live_we       = 1'b1;
                  live_waddr    = got_addr;
                  live_wdata    = 1'b1;
                  if (pop_ff) begin
                     free_count_in = free_count_ff - IW'(1);
                  end else begin
                     last_fresh_in = got;
                  end
               end else begin
                  rsp_status_in = RSP_FULL;
                  rsp_id_in     = '0;
               end
            end
            CMD_RELEASE: begin
               if (live_ok && owner_match) begin
                  rsp_status_in = RSP_OK;
                  live_we       = 1'b1;
                  if (free_count_ff < IW'(MAX_IDS)) begin
                     stk_we        = 1'b1;
                     free_count_in = free_count_ff + IW'(1);
                  end
               end
            end
            CMD_LOOKUP: begin
               if (live_ok) begin
                  rsp_status_in = RSP_OK;
                  rsp_owner_in  = OWNER_PORT_BITS'(own_rdata);
               end
            end
            CMD_TRANSFER: begin
               if (live_ok) begin
                  rsp_status_in = RSP_OK;
                  own_we        = 1'b1;
               end
            end
            default: begin
               rsp_status_in = RSP_INVALID;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= '0;
         last_fresh_ff <= '0;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         free_count_ff <= free_count_in;
         last_fresh_ff <= last_fresh_in;
         if (ctrl.clear) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
         if (ctrl.fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_owner_ff  <= rsp_owner_in;
      end
   end

   assign stat.clear_last = ctrl.clear && (clr_addr_ff == AW'(MAX_IDS - 1));
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_id    = rsp_id_ff;
   assign rsp_result_owner = rsp_owner_ff;

   ida_ram #(.WIDTH(OWNER_BITS), .DEPTH(MAX_IDS)) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_we),
      .wr_addr (own_waddr),
      .wr_data (own_wdata),
      .rd_en   (own_re),
      .rd_addr (req_addr),
      .rd_data (own_rdata)
   );

   ida_ram #(.WIDTH(1), .DEPTH(MAX_IDS)) u_live_ram (
      .clock   (clock),
      .wr_en   (live_we),
      .wr_addr (live_waddr),
      .wr_data (live_wdata),
      .rd_en   (own_re),
      .rd_addr (req_addr),
      .rd_data (live_rdata)
   );

   ida_ram #(.WIDTH(IW), .DEPTH(MAX_IDS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

endmodule

// File: rtl/id_allocator_with_owner_table_top.sv
// A request word is latched, and the owner table, live bits and free stack are read
// as it needs, at the edge that accepts it; rsp_valid rises at the edge that evaluates
// the word and writes the result register, once that register is free. A new request
// is taken only after the previous one has been written to the result register.
// Reset is synchronous and active high; afterwards a clearing pass writes every
// live bit to zero, during which req_ready stays low.
module id_allocator_with_owner_table_top
   import ida_pkg::*;
#(
   parameter int MAX_IDS    = DEFAULT_MAX_IDS,
   parameter int OWNER_BITS = DEFAULT_OWNER_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CMD_BITS-1:0]        req_command,
   input  logic [ID_BITS-1:0]         req_id,
   input  logic [OWNER_PORT_BITS-1:0] req_owner,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_BITS-1:0]     rsp_status,
   output logic [ID_BITS-1:0]         rsp_result_id,
   output logic [OWNER_PORT_BITS-1:0] rsp_result_owner
);

   ida_ctrl_type ctrl;
   ida_stat_type stat;

   ida_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   ida_dp #(.MAX_IDS(MAX_IDS), .OWNER_BITS(OWNER_BITS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_command      (req_command),
      .req_id           (req_id),
      .req_owner        (req_owner),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_result_id    (rsp_result_id),
      .rsp_result_owner (rsp_result_owner)
   );

endmodule

// File: rtl/ida_checker.sv
// Port-level checker for the ID allocator, bound to the top level.
module ida_checker
   import ida_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [CMD_BITS-1:0]        req_command,
   input logic [ID_BITS-1:0]         req_id,
   input logic [OWNER_PORT_BITS-1:0] req_owner,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [STATUS_BITS-1:0]     rsp_status,
   input logic [ID_BITS-1:0]         rsp_result_id,
   input logic [OWNER_PORT_BITS-1:0] rsp_result_owner
);

   // A stalled result word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_result_id) && $stable(rsp_result_owner))
      else $error("result word changed while stalled");

   // Only one request is in flight, so ready drops right after an accept.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == RSP_FULL) |-> (rsp_result_id == '0)
         && (rsp_result_owner == '0))
      else $error("exhausted allocate returned a nonzero field");

   a_owner_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != RSP_OK) |-> (rsp_result_owner == '0))
      else $error("owner returned on a failed request");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == RSP_OK) || (rsp_status == RSP_INVALID)
         || (rsp_status == RSP_FULL))
      else $error("undefined status code");

endmodule

bind id_allocator_with_owner_table_top ida_checker u_ida_checker (.*);
